// File: rtl/core/iclf_pkg.sv
// Shared types and constants for the IPv4 connection limit filter.
// No dependencies.
`default_nettype none
package iclf_pkg;
	localparam int OP_BITS = 3;
	localparam int ADDR_BITS = 32;
	localparam int OUT_CNT_BITS = 16;
	localparam int LIMIT_BITS = 16;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd8;

	localparam logic [OP_BITS-1:0] OP_CHECK = 3'd0;
	localparam logic [OP_BITS-1:0] OP_CONNECT = 3'd1;
	localparam logic [OP_BITS-1:0] OP_DISCONNECT = 3'd2;
	localparam logic [OP_BITS-1:0] OP_ALLOW = 3'd3;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic update;
		logic finish;
	} iclf_cmd_t;

	function automatic logic is_private(input logic [ADDR_BITS-1:0] a);
		return (a[31:24] == 8'd10) || (a[31:20] == 12'hAC1) ||
			(a[31:16] == 16'hC0A8) || (a == 32'h7F000001);
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/ip_connection_limit_filter_top.sv
// Top level of the IPv4 connection limit filter: limit register, controller, datapath.
// Depends on iclf_pkg, iclf_ctrl and iclf_dp.
// A transaction is accepted at the edge where start is high and busy is low.
// Lookup of all three tables, the single update and the report step follow
// in that order, each with busy high. The result then appears for exactly one
// cycle with done, registered at the end of the report step. busy is already low
// in that cycle, so the next start may be accepted there. The receiver cannot
// stall the result. The limit register takes a write only while busy is low
// (cfg_ready follows !busy).
`default_nettype none
module ip_connection_limit_filter_top #(
	parameter int ALLOW_ENTRIES = 16,
	parameter int BLOCK_ENTRIES = 64,
	parameter int TRACK_ENTRIES = 64,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [iclf_pkg::OP_BITS-1:0]     op,
	input  wire logic [iclf_pkg::ADDR_BITS-1:0]   ip_address,
	output logic                                  done,
	output logic                                  allowed,
	output logic                                  table_full,
	output logic [iclf_pkg::OUT_CNT_BITS-1:0]     current_count,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [iclf_pkg::LIMIT_BITS-1:0]  cfg_data
);
	import iclf_pkg::*;
	iclf_cmd_t cmd;
	logic [LIMIT_BITS-1:0] limit_q;

	// hold off limit writes while a transaction is in flight
	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (cfg_valid && cfg_ready) limit_q <= cfg_data;
	end

	iclf_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd);

	iclf_dp #(
		.ALLOW_ENTRIES(ALLOW_ENTRIES), .BLOCK_ENTRIES(BLOCK_ENTRIES),
		.TRACK_ENTRIES(TRACK_ENTRIES), .COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .op, .ip_address, .limit(limit_q),
		.done, .allowed, .table_full, .current_count
	);
endmodule
`default_nettype wire

// File: rtl/core/iclf_ctrl.sv
// Controller sequencing load, lookup, update and report for each transaction.
// Depends on iclf_pkg.
`default_nettype none
module iclf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output iclf_pkg::iclf_cmd_t    cmd
);
	import iclf_pkg::*;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_UPD;
				ST_UPD: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.update = (state_q == ST_UPD);
	assign cmd.finish = (state_q == ST_DONE);
endmodule
`default_nettype wire

// File: rtl/core/iclf_dp.sv
// Datapath: allow, block and track tables with parallel match and lowest-free search.
// Depends on iclf_pkg.
`default_nettype none
module iclf_dp #(
	parameter int ALLOW_ENTRIES = 16,
	parameter int BLOCK_ENTRIES = 64,
	parameter int TRACK_ENTRIES = 64,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  iclf_pkg::iclf_cmd_t                   cmd,
	input  wire logic [iclf_pkg::OP_BITS-1:0]     op,
	input  wire logic [iclf_pkg::ADDR_BITS-1:0]   ip_address,
	input  wire logic [iclf_pkg::LIMIT_BITS-1:0]  limit,
	output logic                                  done,
	output logic                                  allowed,
	output logic                                  table_full,
	output logic [iclf_pkg::OUT_CNT_BITS-1:0]     current_count
);
	import iclf_pkg::*;
	localparam int AW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
	localparam int BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
	localparam int TW = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [ADDR_BITS-1:0] allow_addr_q [ALLOW_ENTRIES];
	logic [ALLOW_ENTRIES-1:0] allow_valid_q;
	logic [ADDR_BITS-1:0] block_addr_q [BLOCK_ENTRIES];
	logic [BLOCK_ENTRIES-1:0] block_valid_q;
	logic [ADDR_BITS-1:0] track_addr_q [TRACK_ENTRIES];
	logic [COUNT_BITS-1:0] track_count_q [TRACK_ENTRIES];
	logic [TRACK_ENTRIES-1:0] track_valid_q;

	logic [OP_BITS-1:0] op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ALLOW_ENTRIES-1:0] a_hit;
	logic [BLOCK_ENTRIES-1:0] b_hit;
	logic [TRACK_ENTRIES-1:0] t_hit;

	// lookup results registered before the update step
	logic exempt_q, allow_hit_q, block_hit_q, t_found_q, b_free_ok_q, t_free_ok_q, a_free_ok_q;
	logic [TW-1:0] t_idx_q, t_free_q;
	logic [BW-1:0] b_free_q;
	logic [AW-1:0] a_free_q;
	logic [COUNT_BITS-1:0] t_cnt_q;
	logic allowed_q, full_q;
	logic [OUT_CNT_BITS-1:0] count_q;
	logic look_q;

	always_comb begin
		for (int i = 0; i < ALLOW_ENTRIES; i++)
			a_hit[i] = allow_valid_q[i] && (allow_addr_q[i] == addr_q);
		for (int i = 0; i < BLOCK_ENTRIES; i++)
			b_hit[i] = block_valid_q[i] && (block_addr_q[i] == addr_q);
		for (int i = 0; i < TRACK_ENTRIES; i++)
			t_hit[i] = track_valid_q[i] && (track_addr_q[i] == addr_q);
	end

	logic [TW-1:0] t_idx_c, t_free_c;
	logic [BW-1:0] b_free_c;
	logic [AW-1:0] a_free_c;
	always_comb begin
		t_idx_c = '0;
		t_free_c = '0;
		b_free_c = '0;
		a_free_c = '0;
		for (int i = TRACK_ENTRIES - 1; i >= 0; i--) begin
			if (t_hit[i]) t_idx_c = TW'(i);
			if (!track_valid_q[i]) t_free_c = TW'(i);
		end
		for (int i = BLOCK_ENTRIES - 1; i >= 0; i--)
			if (!block_valid_q[i]) b_free_c = BW'(i);
		for (int i = ALLOW_ENTRIES - 1; i >= 0; i--)
			if (!allow_valid_q[i]) a_free_c = AW'(i);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			addr_q <= ip_address;
		end
		if (look_q) begin
			allow_hit_q <= |a_hit;
			exempt_q <= is_private(addr_q) || (|a_hit);
			block_hit_q <= |b_hit;
			t_found_q <= |t_hit;
			t_idx_q <= t_idx_c;
			t_cnt_q <= track_count_q[t_idx_c];
			t_free_q <= t_free_c;
			t_free_ok_q <= ~&track_valid_q;
			b_free_q <= b_free_c;
			b_free_ok_q <= ~&block_valid_q;
			a_free_q <= a_free_c;
			a_free_ok_q <= ~&allow_valid_q;
		end
	end

	logic [COUNT_BITS-1:0] t_cnt_new;
	always_comb begin
		t_cnt_new = t_cnt_q;
		if (op_q == OP_CONNECT && t_cnt_q != CNT_MAX) t_cnt_new = t_cnt_q + 1'b1;
		else if (op_q == OP_DISCONNECT && t_cnt_q != '0) t_cnt_new = t_cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			case (op_q)
				OP_CHECK: if (!exempt_q && !block_hit_q && t_found_q &&
						{16'd0, t_cnt_q} >= {{COUNT_BITS{1'b0}}, limit} && b_free_ok_q)
					block_addr_q[b_free_q] <= addr_q;
				OP_CONNECT: if (!exempt_q) begin
					if (t_found_q) track_count_q[t_idx_q] <= t_cnt_new;
					else if (t_free_ok_q) begin
						track_addr_q[t_free_q] <= addr_q;
						track_count_q[t_free_q] <= COUNT_BITS'(1);
					end
				end
				OP_DISCONNECT: if (!exempt_q && t_found_q)
					track_count_q[t_idx_q] <= t_cnt_new;
				OP_ALLOW: if (!allow_hit_q && a_free_ok_q) allow_addr_q[a_free_q] <= addr_q;
				default: ;
			endcase
		end
	end

	logic over_c;
	assign over_c = {16'd0, t_cnt_q} >= {{COUNT_BITS{1'b0}}, limit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_valid_q <= '0;
			block_valid_q <= '0;
			track_valid_q <= '0;
			look_q <= 1'b0;
			done <= 1'b0;
		end else begin
			look_q <= cmd.load;
			done <= cmd.finish;
			if (cmd.update) begin
				case (op_q)
					OP_CHECK: if (!exempt_q && !block_hit_q && t_found_q && over_c &&
							b_free_ok_q) begin
						block_valid_q[b_free_q] <= 1'b1;
						track_valid_q[t_idx_q] <= 1'b0;
					end
					OP_CONNECT: if (!exempt_q && !t_found_q && t_free_ok_q)
						track_valid_q[t_free_q] <= 1'b1;
					OP_DISCONNECT: if (!exempt_q && t_found_q && t_cnt_new == '0)
						track_valid_q[t_idx_q] <= 1'b0;
					OP_ALLOW: if (!allow_hit_q && a_free_ok_q) allow_valid_q[a_free_q] <= 1'b1;
					OP_CLEAR: begin
						block_valid_q <= '0;
						track_valid_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// result computed from the lookup during update, registered and held until done reports it
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			allowed_q <= 1'b0;
			full_q <= 1'b0;
			count_q <= t_found_q ? OUT_CNT_BITS'(t_cnt_q) : '0;
			case (op_q)
				OP_CHECK: begin
					if (exempt_q) allowed_q <= 1'b1;
					else if (block_hit_q) allowed_q <= 1'b0;
					else if (t_found_q && over_c) begin
						if (b_free_ok_q) count_q <= '0;
						else full_q <= 1'b1;
					end else allowed_q <= 1'b1;
				end
				OP_CONNECT: if (!exempt_q) begin
					if (t_found_q) count_q <= OUT_CNT_BITS'(t_cnt_new);
					else if (t_free_ok_q) count_q <= OUT_CNT_BITS'(1);
					else full_q <= 1'b1;
				end
				OP_DISCONNECT: if (!exempt_q && t_found_q)
					count_q <= OUT_CNT_BITS'(t_cnt_new);
				OP_ALLOW: if (!allow_hit_q && !a_free_ok_q) full_q <= 1'b1;
				OP_CLEAR: count_q <= '0;
				default: ;
			endcase
		end
	end

	assign allowed = allowed_q;
	assign table_full = full_q;
	assign current_count = count_q;
endmodule
`default_nettype wire

// File: rtl/core/iclf_checker.sv
// Port-level checks for the connection limit filter, bound to the top level.
// Depends on ip_connection_limit_filter_top.
`default_nettype none
module iclf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        allowed,
	input wire logic        table_full
);
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done) else $error("done not four cycles after start");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_full_not_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(allowed && table_full)) else $error("allowed with table_full");
endmodule

bind ip_connection_limit_filter_top iclf_checker u_iclf_checker (
	.clk, .arst_n, .start, .busy, .done, .allowed, .table_full
);
`default_nettype wire

// File: test/tb.sv
// Self-checking bench for ip_connection_limit_filter_top: queued driver, strobe monitor,
// in-bench table model predicting allowed, table_full and current_count per transaction.
// Depends on iclf_pkg and the RTL top level.
`default_nettype none
module tb;
	import iclf_pkg::*;

	localparam int N_ALLOW = 16;
	localparam int N_BLOCK = 64;
	localparam int N_TRACK = 64;
	localparam logic [15:0] COUNT_SAT = 16'hFFFF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic [ADDR_BITS-1:0] addr;
	} request_t;

	typedef struct packed {
		logic allowed;
		logic full;
		logic [15:0] count;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [OP_BITS-1:0] op = '0;
	logic [ADDR_BITS-1:0] ip_address = '0;
	logic done;
	logic allowed;
	logic table_full;
	logic [OUT_CNT_BITS-1:0] current_count;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;

	ip_connection_limit_filter_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.ip_address(ip_address), .done(done), .allowed(allowed),
		.table_full(table_full), .current_count(current_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// filter model state
	logic [15:0] limit_q = LIMIT_RESET;
	logic [31:0] allow_tab [N_ALLOW];
	logic allow_ok [N_ALLOW];
	logic [31:0] block_tab [N_BLOCK];
	logic block_ok [N_BLOCK];
	logic [31:0] track_tab [N_TRACK];
	logic [15:0] track_cnt [N_TRACK];
	logic track_ok [N_TRACK];

	request_t pending [$];
	verdict_t verdicts [$];
	logic hold_send = 0;
	int gap = 0;
	int errors = 0;
	int stall = 0;
	logic timed_out = 0;
	logic [31:0] pool [8];

	function automatic int find_allow(logic [31:0] a);
		for (int i = 0; i < N_ALLOW; i++) if (allow_ok[i] && allow_tab[i] == a) return i;
		return -1;
	endfunction

	function automatic int find_block(logic [31:0] a);
		for (int i = 0; i < N_BLOCK; i++) if (block_ok[i] && block_tab[i] == a) return i;
		return -1;
	endfunction

	function automatic int find_track(logic [31:0] a);
		for (int i = 0; i < N_TRACK; i++) if (track_ok[i] && track_tab[i] == a) return i;
		return -1;
	endfunction

	function automatic verdict_t admit(request_t r);
		verdict_t v;
		logic exempt;
		int t;
		int f;
		v = '0;
		exempt = is_addr_private(r.addr) || find_allow(r.addr) >= 0;
		t = find_track(r.addr);
		f = -1;
		case (r.op)
			OP_CHECK: begin
				if (exempt) v.allowed = 1;
				else if (find_block(r.addr) >= 0) v.allowed = 0;
				else if (t >= 0 && track_cnt[t] >= limit_q) begin
					for (int i = N_BLOCK - 1; i >= 0; i--) if (!block_ok[i]) f = i;
					if (f >= 0) begin
						block_tab[f] = r.addr;
						block_ok[f] = 1;
						track_ok[t] = 0;
						track_cnt[t] = 0;
					end else v.full = 1;
				end else v.allowed = 1;
			end
			OP_CONNECT: begin
				if (!exempt) begin
					if (t >= 0) begin
						if (track_cnt[t] != COUNT_SAT) track_cnt[t]++;
					end else begin
						for (int i = N_TRACK - 1; i >= 0; i--) if (!track_ok[i]) f = i;
						if (f >= 0) begin
							track_tab[f] = r.addr;
							track_cnt[f] = 1;
							track_ok[f] = 1;
						end else v.full = 1;
					end
				end
			end
			OP_DISCONNECT: begin
				if (!exempt && t >= 0) begin
					if (track_cnt[t] > 0) track_cnt[t]--;
					if (track_cnt[t] == 0) track_ok[t] = 0;
				end
			end
			OP_ALLOW: begin
				if (find_allow(r.addr) < 0) begin
					for (int i = N_ALLOW - 1; i >= 0; i--) if (!allow_ok[i]) f = i;
					if (f >= 0) begin
						allow_tab[f] = r.addr;
						allow_ok[f] = 1;
					end else v.full = 1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < N_BLOCK; i++) block_ok[i] = 0;
				for (int i = 0; i < N_TRACK; i++) track_ok[i] = 0;
			end
			default: ;
		endcase
		t = find_track(r.addr);
		v.count = (t >= 0) ? track_cnt[t] : 16'd0;
		return v;
	endfunction

	function automatic logic is_addr_private(logic [31:0] a);
		return a[31:24] == 8'd10 || a[31:20] == 12'hAC1 || a[31:16] == 16'hC0A8 ||
			a == 32'h7F000001;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 4) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// driver: predict at the accepting edge, advance at the falling edge
	always @(posedge clk) begin
		if (start && !busy && arst_n) verdicts.push_back(admit(pending.pop_front()));
	end

	// start is only raised while busy is low, so busy seen high with start means accepted
	always @(negedge clk) begin
		if (start && busy) begin
			start <= 0;
			gap = pick_gap();
		end else if (!start) begin
			if (gap > 0) gap--;
			else if (pending.size() > 0 && !hold_send && arst_n && !busy) begin
				start <= 1;
				op <= pending[0].op;
				ip_address <= pending[0].addr;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (done) begin
			if (verdicts.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				verdict_t e;
				e = verdicts.pop_front();
				if (allowed !== e.allowed) begin
					$error("allowed exp %0d got %0d", e.allowed, allowed);
					errors++;
				end
				if (table_full !== e.full) begin
					$error("table_full exp %0d got %0d", e.full, table_full);
					errors++;
				end
				if (current_count !== e.count) begin
					$error("current_count exp %0d got %0d", e.count, current_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (done || (start && !busy) || (cfg_valid && cfg_ready))
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic drain();
		while (pending.size() > 0 || verdicts.size() > 0 || start) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		limit_q = value;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send(logic [OP_BITS-1:0] o, logic [31:0] a);
		request_t r;
		r.op = o;
		r.addr = a;
		pending.push_back(r);
	endtask

	function automatic logic [31:0] public_addr();
		logic [31:0] a;
		a = $urandom;
		if (is_addr_private(a)) a[31] = ~a[31];
		return a;
	endfunction

	task automatic random_phase(int n, int pool_size);
		for (int i = 0; i < n; i++) begin
			int k;
			logic [31:0] a;
			k = $urandom_range(0, 99);
			a = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
			if (k < 40) send(OP_CONNECT, a);
			else if (k < 65) send(OP_CHECK, a);
			else if (k < 85) send(OP_DISCONNECT, a);
			else if (k < 90) send(OP_ALLOW, $urandom_range(0, 3) == 0 ? a : public_addr());
			else if (k < 93) send(OP_CLEAR, a);
			else if (k < 96) send(3'(5 + $urandom_range(0, 2)), a);
			else send(OP_CONNECT, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < N_ALLOW; i++) allow_ok[i] = 0;
		for (int i = 0; i < N_BLOCK; i++) block_ok[i] = 0;
		for (int i = 0; i < N_TRACK; i++) begin
			track_ok[i] = 0;
			track_cnt[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: private ranges and extremes under the reset limit
		send(OP_CHECK, 32'h0A000000);
		send(OP_CONNECT, 32'hAC1FFFFF);
		send(OP_CONNECT, 32'hC0A80101);
		send(OP_CONNECT, 32'h7F000001);
		send(OP_CONNECT, 32'h7F000002);
		send(OP_CONNECT, 32'h00000000);
		send(OP_CONNECT, 32'hFFFFFFFF);
		send(OP_DISCONNECT, 32'h12345678);
		send(OP_DISCONNECT, 32'h7F000002);
		send(OP_ALLOW, 32'hFFFFFFFF);
		send(OP_ALLOW, 32'hFFFFFFFF);
		send(OP_CHECK, 32'hFFFFFFFF);
		send(OP_CONNECT, 32'hFFFFFFFF);
		send(3'd7, 32'h00000000);
		send(3'd5, 32'hFFFFFFFF);
		send(OP_CLEAR, 32'h0);
		drain();

		// limit 0: a single connect then check blocks the address
		set_limit(16'd0);
		send(OP_CONNECT, 32'h01020304);
		send(OP_CHECK, 32'h01020304);
		send(OP_CHECK, 32'h01020304);
		send(OP_CONNECT, 32'h01020304);
		send(OP_CHECK, 32'h01020304);
		// fill the allow list past its depth
		for (int i = 0; i < N_ALLOW + 2; i++) send(OP_ALLOW, 32'h20000000 + i);
		// fill the block table, then overflow it
		for (int i = 0; i < N_BLOCK + 1; i++) begin
			send(OP_CONNECT, 32'h30000000 + i);
			send(OP_CHECK, 32'h30000000 + i);
		end
		drain();
		// fill the track table, then overflow it
		send(OP_CLEAR, 32'h0);
		for (int i = 0; i < N_TRACK + 2; i++) send(OP_CONNECT, 32'h40000000 + i);
		drain();
		// move to the top limit and clear the tables
		set_limit(16'hFFFF);
		send(OP_CLEAR, 32'h0);
		drain();
		for (int i = 0; i < N_TRACK; i++) begin
			track_ok[i] = 0;
		end
		begin
			// preload one entry near saturation by repeated connects would take 65k items;
			// instead check at the top limit with small counts
			send(OP_CONNECT, 32'h50000000);
			send(OP_CHECK, 32'h50000000);
			send(OP_DISCONNECT, 32'h50000000);
			send(OP_DISCONNECT, 32'h50000000);
		end
		drain();

		// random phases across several limits; pause for a full drain at each boundary
		for (int ph = 0; ph < 6; ph++) begin
			set_limit(ph == 0 ? 16'd1 : ph == 5 ? 16'hFFFF : 16'($urandom_range(1, 6)));
			for (int i = 0; i < 8; i++) pool[i] = public_addr();
			random_phase(35, 8);
			drain();
		end
		hold_send = 0;

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
rtl/core/iclf_pkg.sv
rtl/core/iclf_ctrl.sv
rtl/core/iclf_dp.sv
rtl/core/ip_connection_limit_filter_top.sv
rtl/core/iclf_checker.sv
test/tb.sv
